[src/xeu_pkg.sv]
package xeu_pkg;

	// Longest burst one input word can cause: '&', four held letters, current byte
	localparam int unsigned MaxBurst   = 6;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned NumEnt     = 5;
	localparam int unsigned MaxHeld    = 5;

	localparam logic [7:0] AmpChar = 8'h26;

	typedef logic [7:0] byte_t;

	// One queued burst: bytes in send order, byte count and end-of-message flag
	typedef struct packed {
		logic [MaxBurst-1:0][7:0] data;
		logic [2:0]               count;
		logic                     last;
	} burst_t;

	// Entity name letters, element 0 first; unused tail is zero
	function automatic logic [4:0][7:0] ent_name(input logic [2:0] e);
		logic [4:0][7:0] r;
		unique case (e)
			3'd0:    r = {8'h00, ";", "p", "m", "a"};
			3'd1:    r = {";", "t", "o", "u", "q"};
			3'd2:    r = {";", "s", "o", "p", "a"};
			3'd3:    r = {8'h00, 8'h00, ";", "t", "l"};
			3'd4:    r = {8'h00, 8'h00, ";", "t", "g"};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Held count at which the entity completes (ampersand plus name letters)
	function automatic logic [2:0] ent_len(input logic [2:0] e);
		logic [2:0] r;
		unique case (e)
			3'd0:    r = 3'd4;
			3'd1:    r = 3'd5;
			3'd2:    r = 3'd5;
			3'd3:    r = 3'd3;
			3'd4:    r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ent_char(input logic [2:0] e);
		logic [7:0] r;
		unique case (e)
			3'd0:    r = AmpChar;
			3'd1:    r = 8'h22;
			3'd2:    r = 8'h27;
			3'd3:    r = 8'h3C;
			3'd4:    r = 8'h3E;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[src/xeu_front.sv]
module xeu_front import xeu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  byte_t  in_byte,
	input  logic   in_last,
	output logic   push,
	output burst_t burst
);

	logic [2:0]      pending_q;
	logic [3:0][7:0] letters_q;

	logic [2:0]      held;
	logic [2:0]      nh;
	logic [2:0]      k;
	logic            complete;
	logic [7:0]      comp_char;
	logic            prefix;
	logic            ok;
	logic [4:0][7:0] nm;
	logic [3:0][7:0] nl;
	logic            wr_letter;
	logic [1:0]      wr_idx;

	// Classify the word against the held prefix and build its burst
	always_comb begin
		held      = (pending_q > 3'(MaxHeld)) ? 3'd0 : pending_q;
		complete  = 1'b0;
		comp_char = 8'h00;
		prefix    = 1'b0;
		for (int e = 0; e < NumEnt; e++) begin
			nm = ent_name(3'(e));
			ok = (held != 3'd0) && (held <= ent_len(3'(e)))
				&& (in_byte == nm[3'(held - 3'd1)]);
			for (int i = 0; i < 4; i++) begin
				if ((3'(i + 1) < held) && (letters_q[i] != nm[i]))
					ok = 1'b0;
			end
			if (ok && held == ent_len(3'(e))) begin
				complete  = 1'b1;
				comp_char = ent_char(3'(e));
			end else if (ok) begin
				prefix = 1'b1;
			end
		end

		burst.data = '0;
		k          = 3'd0;
		nh         = held;
		nl         = letters_q;
		wr_letter  = 1'b0;
		wr_idx     = 2'(held - 3'd1);
		if (held == 3'd0) begin
			if (in_byte == AmpChar) begin
				nh = 3'd1;
			end else begin
				burst.data[0] = in_byte;
				k = 3'd1;
			end
		end else if (complete) begin
			burst.data[0] = comp_char;
			k  = 3'd1;
			nh = 3'd0;
		end else if (prefix && held <= 3'd4) begin
			wr_letter  = 1'b1;
			nl[wr_idx] = in_byte;
			nh = held + 3'd1;
		end else begin
			// Mismatch: flush the ampersand and letters, then treat the word as plain input
			burst.data[0] = AmpChar;
			for (int i = 0; i < 4; i++) begin
				if (3'(i + 1) < held)
					burst.data[i + 1] = letters_q[i];
			end
			k  = held;
			nh = 3'd0;
			if (in_byte == AmpChar) begin
				nh = 3'd1;
			end else begin
				burst.data[k] = in_byte;
				k = k + 3'd1;
			end
		end

		// Flush anything still held at message end
		if (in_last && nh != 3'd0) begin
			burst.data[k] = AmpChar;
			for (int i = 0; i < 4; i++) begin
				if (3'(i + 1) < nh)
					burst.data[i + 1] = nl[i];
			end
			k  = k + nh;
			nh = 3'd0;
		end

		burst.count = k;
		burst.last  = in_last;
		push        = accept && (k != 3'd0);
	end

	// Hold the prefix state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (accept) begin
			pending_q <= nh;
		end
	end

	// Store the newly matched letter
	always_ff @(posedge clk) begin
		if (accept && wr_letter)
			letters_q[wr_idx] <= in_byte;
	end

	property p_held_range;
		@(posedge clk) disable iff (!arst_n) pending_q <= 3'(MaxHeld);
	endproperty
	a_held_range: assert property (p_held_range)
		else $error("held count out of range");

endmodule

[src/xeu_queue.sv]
module xeu_queue import xeu_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  burst_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output burst_t head
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	burst_t            mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// Write the burst storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) push |-> !full;
	endproperty
	a_no_overflow: assert property (p_no_overflow)
		else $error("burst pushed into full queue");

endmodule

[src/xeu_back.sv]
module xeu_back import xeu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  burst_t head,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_stall,
	output byte_t  out_byte,
	output logic   run_last,
	output logic   message_end
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	byte_t      out_byte_q;
	logic       run_last_q;
	logic       message_end_q;
	logic       load;
	logic       end_of_burst;

	assign load         = !out_valid_q || !out_stall;
	assign end_of_burst = (idx_q == head.count - 3'd1);
	assign pop          = load && head_valid && end_of_burst;

	// Advance through the head burst one word per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid)
				idx_q <= end_of_burst ? 3'd0 : idx_q + 3'd1;
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_byte_q    <= head.data[idx_q];
			run_last_q    <= end_of_burst;
			message_end_q <= end_of_burst && head.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign message_end = message_end_q;

	property p_end_is_run_last;
		@(posedge clk) disable iff (!arst_n) out_valid_q && message_end_q |-> run_last_q;
	endproperty
	a_end_is_run_last: assert property (p_end_is_run_last)
		else $error("message end without run last");

	property p_idx_in_burst;
		@(posedge clk) disable iff (!arst_n) head_valid |-> (idx_q < head.count);
	endproperty
	a_idx_in_burst: assert property (p_idx_in_burst)
		else $error("burst index past burst length");

	property p_idx_idle;
		@(posedge clk) disable iff (!arst_n) !head_valid |-> (idx_q == 3'd0);
	endproperty
	a_idx_idle: assert property (p_idx_idle)
		else $error("burst index nonzero with empty queue");

endmodule

[src/xml_entity_unescaper.sv]
// XML predefined entity decoder.
// Input channel (in_valid / in_stall): one escaped text byte per word, with
// in_last on the final byte of a message. A word is taken on a rising edge
// with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one decoded byte per word; run_last
// marks the last byte caused by an input word, message_end the final byte of
// the message. Words that only extend an entity prefix produce nothing.
// The front end decodes each input word into a burst of 0 to 6 bytes in the
// same cycle and pushes it into a FIFO_DEPTH entry burst queue; the back end
// sends one byte per cycle while out_stall is low, from the queue head through
// an output register, so each byte passes the queue and then that register.
// Throughput: one input word per cycle while bursts hold one byte and the
// output is not stalled; the back end's single output byte per cycle sets the
// rate when longer bursts occur, with in_stall raised while the queue is full.
// Reset clears the prefix state, the queue and the output register.
// While out_stall is high the output word holds and the queue keeps filling.
module xml_entity_unescaper import xeu_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  byte_t in_byte,
	input  logic  in_last,
	output logic  out_valid,
	input  logic  out_stall,
	output byte_t out_byte,
	output logic  run_last,
	output logic  message_end
);

	logic   accept;
	logic   push;
	burst_t burst;
	logic   full;
	logic   pop;
	logic   head_valid;
	burst_t head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	xeu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.in_last (in_last),
		.push    (push),
		.burst   (burst)
	);

	xeu_queue #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (burst),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	xeu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule

[tb/xml_entity_unescaper_tb.sv]
`timescale 1ns / 1ps

module xml_entity_unescaper_tb import xeu_pkg::*;;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_WORDS = 80;
	localparam int unsigned PRINT_CAP   = 40;

	// one input word waiting to be sent
	typedef struct packed {
		byte_t data;
		logic  msg_last;
	} text_word_t;

	// one decoded output word as the block should present it
	typedef struct packed {
		byte_t data;
		logic  run_end;
		logic  msg_end;
	} decoded_word_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	byte_t in_byte = 8'h00;
	logic  in_last = 1'b0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	byte_t out_byte;
	logic  run_last;
	logic  message_end;

	xml_entity_unescaper uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.message_end(message_end)
	);

	// entity names after the ampersand and the characters they stand for
	string ent_names [NumEnt] = '{"amp;", "quot;", "apos;", "lt;", "gt;"};
	byte_t ent_glyph [NumEnt] = '{8'h26, 8'h22, 8'h27, 8'h3C, 8'h3E};

	text_word_t    pending[$];
	decoded_word_t decoded_q[$];
	byte_t         step_bytes[$];

	// decoder state: held count includes the ampersand
	int unsigned held_cnt = 0;
	byte_t       held_let [4];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	logic        in_took = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned err_count = 0;
	int unsigned words_queued = 0;
	int unsigned words_in = 0;
	int unsigned words_out = 0;
	int unsigned ent_hits = 0;
	int unsigned spills = 0;
	int unsigned longest_run = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// emit the ampersand and every held letter literally
	function automatic void spill_held(input int unsigned n);
		int unsigned i;
		step_bytes.push_back(AmpChar);
		for (i = 0; i + 1 < n; i++)
			step_bytes.push_back(held_let[i]);
		spills++;
	endfunction

	// advance the decoder by one input word and queue the bytes it yields
	function automatic void decode_step(input byte_t b, input logic last);
		int unsigned n;
		int unsigned e;
		int unsigned i;
		int          done_ent;
		bit          partial;
		bit          ok;
		decoded_word_t w;
		n = held_cnt;
		step_bytes.delete();
		if (n == 0) begin
			if (b == AmpChar)
				n = 1;
			else
				step_bytes.push_back(b);
		end else begin
			done_ent = -1;
			partial = 1'b0;
			for (e = 0; e < NumEnt; e++) begin
				if (n <= ent_names[e].len()) begin
					ok = (b == ent_names[e][n-1]);
					for (i = 0; i + 1 < n; i++)
						if (held_let[i] != ent_names[e][i])
							ok = 1'b0;
					if (ok && n == ent_names[e].len())
						done_ent = e;
					else if (ok)
						partial = 1'b1;
				end
			end
			if (done_ent >= 0) begin
				step_bytes.push_back(ent_glyph[done_ent]);
				ent_hits++;
				n = 0;
			end else if (partial && n <= 4) begin
				held_let[n-1] = b;
				n++;
			end else begin
				// mismatch: replay the held run, then treat this byte as fresh input
				spill_held(n);
				n = 0;
				if (b == AmpChar)
					n = 1;
				else
					step_bytes.push_back(b);
			end
		end
		if (last && n != 0) begin
			spill_held(n);
			n = 0;
		end
		held_cnt = n;
		if (step_bytes.size() > longest_run)
			longest_run = step_bytes.size();
		for (i = 0; i < step_bytes.size(); i++) begin
			w.data    = step_bytes[i];
			w.run_end = (i + 1 == step_bytes.size());
			w.msg_end = (i + 1 == step_bytes.size()) && last;
			decoded_q.push_back(w);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (err_count < PRINT_CAP)
			$display("%0t: %s mismatch on output word %0d: got %h, expected %h",
				$realtime, what, words_out, got, want);
		err_count++;
	endtask

	task automatic push_byte(input byte_t b, input logic last);
		text_word_t t;
		t.data = b;
		t.msg_last = last;
		pending.push_back(t);
		words_queued++;
	endtask

	task automatic push_text(input string s, input bit end_msg);
		int unsigned k;
		for (k = 0; k < s.len(); k++)
			push_byte(s[k], end_msg && (k + 1 == s.len()));
	endtask

	// build one message: entities most often, with broken prefixes and noise mixed in
	task automatic add_message();
		byte_t       msg[$];
		int unsigned ntok;
		int unsigned kind;
		int unsigned e;
		int unsigned cut;
		int unsigned k;
		byte_t       brk;
		ntok = $urandom_range(1, 8);
		repeat (ntok) begin
			kind = $urandom_range(0, 11);
			e = $urandom_range(0, NumEnt - 1);
			cut = $urandom_range(0, ent_names[e].len() - 1);
			if (kind <= 4) begin
				msg.push_back(AmpChar);
				for (k = 0; k < ent_names[e].len(); k++)
					msg.push_back(ent_names[e][k]);
			end else if (kind <= 7) begin
				msg.push_back(AmpChar);
				for (k = 0; k < cut; k++)
					msg.push_back(ent_names[e][k]);
				case ($urandom_range(0, 2))
					0: brk = AmpChar;
					1: brk = ent_names[e][cut] ^ 8'h20;
					default: brk = 8'($urandom_range(0, 255));
				endcase
				msg.push_back(brk);
			end else if (kind <= 9) begin
				msg.push_back(8'($urandom_range(0, 255)));
			end else if (kind == 10) begin
				msg.push_back(AmpChar);
			end else begin
				// dangling prefix, left for the next token or the message end
				msg.push_back(AmpChar);
				for (k = 0; k < cut; k++)
					msg.push_back(ent_names[e][k]);
			end
		end
		for (k = 0; k < msg.size(); k++)
			push_byte(msg[k], k + 1 == msg.size());
	endtask

	// hold off until every queued word is sent and every decoded word has come
	task automatic drain();
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid || decoded_q.size() != 0);
	endtask

	// drive input words at the falling edge; hold a word until it is taken
	always @(negedge clk) begin : drive
		text_word_t t;
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					t = pending.pop_front();
					in_valid <= 1'b1;
					in_byte  <= t.data;
					in_last  <= t.msg_last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// predict on accepted input words, check accepted output words
	always @(posedge clk) begin : observe
		decoded_word_t want;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				decode_step(in_byte, in_last);
				words_in++;
			end
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("unexpected word", out_byte, 8'h00);
				end else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.data)
						report_mismatch("out_byte", out_byte, want.data);
					if (run_last !== want.run_end)
						report_mismatch("run_last", 8'(run_last), 8'(want.run_end));
					if (message_end !== want.msg_end)
						report_mismatch("message_end", 8'(message_end),
							8'(want.msg_end));
				end
				words_out++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, decoded_q.size());
			$display("xml_entity_unescaper test failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned ph;
		int unsigned target;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes, a six-byte burst, ampersand replay, flush at end
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_text("&lt;", 1'b0);
		push_text("&apos", 1'b0);
		push_byte(8'hFF, 1'b0);
		push_text("&a&gt;", 1'b0);
		push_text("&quot;", 1'b1);
		push_text("&q", 1'b1);
		drain();

		// random messages under each idling mix; pause for a full drain between
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 59;
				end
				default: begin
					send_idle_pct = 18;
					stall_pct = 18;
				end
			endcase
			target = words_queued + PHASE_WORDS;
			while (words_queued < target)
				add_message();
			drain();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (12) @(negedge clk);
		$display("sent %0d text words, checked %0d decoded words in %0d cycles",
			words_in, words_out, cycle_count);
		$display("decoded %0d entities, replayed %0d held runs, longest burst %0d",
			ent_hits, spills, longest_run);
		if (err_count == 0) begin
			$display("xml_entity_unescaper test passed");
		end else begin
			$display("%0d mismatches", err_count);
			$display("xml_entity_unescaper test failed");
		end
		$finish;
	end

endmodule
